FILE: hdl/rsfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsfp_pkg;

  localparam logic [7:0] DELIMITER         = 8'h7E;
  localparam logic [7:0] ABORT_TYPE        = 8'd97;
  localparam logic [2:0] HEADER_BYTES      = 3'd7;
  localparam logic [2:0] HDR_POS_TYPE      = 3'd2;
  localparam logic [2:0] HDR_POS_SRC_LOW   = 3'd4;
  localparam logic [1:0] LAST_CHANNEL      = 2'd2;
  localparam logic [7:0] ACCEPTED_SRC_RST  = 8'd2;

  typedef struct packed {
    logic [15:0] reading_home;
    logic [15:0] reading_away;
    logic [15:0] reading_timer;
    logic [7:0]  sample_index;
    logic        last_sample;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/rsfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module rsfp_parser
  import rsfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_vld,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] accepted_source,
  output logic            res_vld,
  output result_t         res
);

  localparam logic [2:0] PH_HUNT     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_COUNT    = 3'd2;
  localparam logic [2:0] PH_MASK     = 3'd3;
  localparam logic [2:0] PH_ZERO     = 3'd4;
  localparam logic [2:0] PH_SAMPLES  = 3'd5;
  localparam logic [2:0] PH_CHECKSUM = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [2:0]  hdr_pos_r, hdr_pos_nxt;
  logic [7:0]  src_low_r, src_low_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [7:0]  done_r, done_nxt;
  logic [1:0]  chan_r, chan_nxt;
  logic        exp_low_r, exp_low_nxt;
  logic [7:0]  held_high_r, held_high_nxt;
  logic [15:0] held0_r, held0_nxt;
  logic [15:0] held1_r, held1_nxt;

  logic [15:0] reading;
  logic [2:0]  hdr_pos_inc;
  logic        is_last;

  assign reading     = {held_high_r, byte_in};
  assign hdr_pos_inc = hdr_pos_r + 3'd1;
  assign is_last     = ({1'b0, done_r} + 9'd1) >= {1'b0, total_r};

  always_comb begin
    phase_nxt     = phase_r;
    hdr_pos_nxt   = hdr_pos_r;
    src_low_nxt   = src_low_r;
    total_nxt     = total_r;
    done_nxt      = done_r;
    chan_nxt      = chan_r;
    exp_low_nxt   = exp_low_r;
    held_high_nxt = held_high_r;
    held0_nxt     = held0_r;
    held1_nxt     = held1_r;
    res_vld       = 1'b0;
    res.reading_home  = held0_r;
    res.reading_away  = held1_r;
    res.reading_timer = reading;
    res.sample_index  = done_r;
    res.last_sample   = is_last;

    if (byte_vld) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (byte_in == DELIMITER) begin
            phase_nxt   = PH_HEADER;
            hdr_pos_nxt = 3'd0;
          end
        end
        PH_HEADER: begin
          if (hdr_pos_r == HDR_POS_TYPE && byte_in == ABORT_TYPE) begin
            phase_nxt   = PH_HUNT;
            hdr_pos_nxt = 3'd0;
          end else begin
            if (hdr_pos_r == HDR_POS_SRC_LOW) begin
              src_low_nxt = byte_in;
            end
            if (hdr_pos_inc >= HEADER_BYTES) begin
              hdr_pos_nxt = 3'd0;
              phase_nxt   = PH_COUNT;
            end else begin
              hdr_pos_nxt = hdr_pos_inc;
            end
          end
        end
        PH_COUNT: begin
          total_nxt = byte_in;
          done_nxt  = 8'd0;
          phase_nxt = PH_MASK;
        end
        PH_MASK: begin
          phase_nxt = PH_ZERO;
        end
        PH_ZERO: begin
          chan_nxt    = 2'd0;
          exp_low_nxt = 1'b0;
          phase_nxt   = (total_r == 8'd0) ? PH_CHECKSUM : PH_SAMPLES;
        end
        PH_SAMPLES: begin
          if (!exp_low_r) begin
            held_high_nxt = byte_in;
            exp_low_nxt   = 1'b1;
          end else begin
            exp_low_nxt = 1'b0;
            if (chan_r < LAST_CHANNEL) begin
              if (chan_r[0]) begin
                held1_nxt = reading;
              end else begin
                held0_nxt = reading;
              end
              chan_nxt = chan_r + 2'd1;
            end else begin
              chan_nxt = 2'd0;
              res_vld  = (src_low_r == accepted_source);
              done_nxt = done_r + 8'd1;
              if (is_last) begin
                phase_nxt = PH_CHECKSUM;
              end
            end
          end
        end
        PH_CHECKSUM: begin
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hdr_pos_r   <= 3'd0;
      src_low_r   <= 8'd0;
      total_r     <= 8'd0;
      done_r      <= 8'd0;
      chan_r      <= 2'd0;
      exp_low_r   <= 1'b0;
      held_high_r <= 8'd0;
      held0_r     <= 16'd0;
      held1_r     <= 16'd0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      src_low_r   <= src_low_nxt;
      total_r     <= total_nxt;
      done_r      <= done_nxt;
      chan_r      <= chan_nxt;
      exp_low_r   <= exp_low_nxt;
      held_high_r <= held_high_nxt;
      held0_r     <= held0_nxt;
      held1_r     <= held1_nxt;
    end
  end

  a_res_in_samples: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (phase_r == PH_SAMPLES && exp_low_r && chan_r == LAST_CHANNEL))
    else $error("result outside sample phase");

  a_last_to_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.last_sample) |=> (phase_r == PH_CHECKSUM))
    else $error("last sample did not move to checksum");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SAMPLES) |-> (chan_r != 2'd3))
    else $error("channel position out of range");

endmodule

`default_nettype wire

FILE: hdl/rsfp_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module rsfp_outq
  import rsfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         room,
  output logic         pop_vld,
  input  wire logic    pop_stall,
  output result_t      pop_data
);

  result_t     mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r, count_nxt;
  logic        pop;

  assign room     = (count_r != 2'd2);
  assign pop_vld  = (count_r != 2'd0);
  assign pop      = pop_vld && !pop_stall;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room)
    else $error("result pushed into full queue");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd0 || count_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: hdl/radio_io_sample_frame_parser_top.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_rx_byte
// out      output     out_valid/ out_stall out_reading_home, out_reading_away,
//                                          out_reading_timer, out_sample_index,
//                                          out_last_sample
// cfg      input      cfg_valid/ cfg_ready cfg_accepted_source
//
// One byte per cycle while in_stall is low. A byte is registered, then parsed;
// a result is written to the result queue and offered on out from there.
// A two-entry result queue absorbs stalls; in_stall rises only when it is full.
// rst_n is synchronous: parser returns to delimiter hunt, accepted source to 2.
`timescale 1ns / 1ps
`default_nettype none

module radio_io_sample_frame_parser_top
  import rsfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_reading_home,
  output logic [15:0]      out_reading_away,
  output logic [15:0]      out_reading_timer,
  output logic [7:0]       out_sample_index,
  output logic             out_last_sample,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_accepted_source
);

  logic [7:0] acc_src_r;
  logic [7:0] byte_r;
  logic       byte_vld_r;
  logic       room;
  logic       adv;
  logic       res_vld;
  result_t    res;
  result_t    q_data;

  assign cfg_ready = 1'b1;
  assign adv       = byte_vld_r && room;
  assign in_stall  = byte_vld_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_src_r <= ACCEPTED_SRC_RST;
    end else if (cfg_valid && cfg_ready) begin
      acc_src_r <= cfg_accepted_source;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (!in_stall) begin
      byte_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  rsfp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .byte_vld        (adv),
    .byte_in         (byte_r),
    .accepted_source (acc_src_r),
    .res_vld         (res_vld),
    .res             (res)
  );

  rsfp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .room      (room),
    .pop_vld   (out_valid),
    .pop_stall (out_stall),
    .pop_data  (q_data)
  );

  assign out_reading_home  = q_data.reading_home;
  assign out_reading_away  = q_data.reading_away;
  assign out_reading_timer = q_data.reading_timer;
  assign out_sample_index  = q_data.sample_index;
  assign out_last_sample   = q_data.last_sample;

  a_parse_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> byte_vld_r)
    else $error("result without a registered byte");

endmodule

`default_nettype wire
